// ===== hw/rtl/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg: shared constants and types of the RMS pixel difference block
// Widths of the accumulator, divider and square root unit, register indexes
// and the status struct that the iterative units report with.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 8;

  localparam int COLOUR_W  = 8;
  localparam int SQ_W      = 2 * COLOUR_W;
  localparam int DIM_W     = 13;
  localparam int SIDE_W    = $clog2(MAX_DIM + 1);
  localparam int MAX_TOTAL = MAX_DIM * MAX_DIM;
  localparam int CNT_W     = $clog2(MAX_TOTAL + 1);
  localparam int DEN_W     = $clog2(3 * MAX_TOTAL + 1);

  localparam longint SQ_MAX  = longint'((2 ** COLOUR_W - 1) * (2 ** COLOUR_W - 1));
  localparam longint MAX_SUM = 3 * SQ_MAX * longint'(MAX_TOTAL);
  localparam int SUM_W       = $clog2(MAX_SUM + 1);

  // The mean of the squared differences stays below 2^SQ_W, so the scaled
  // quotient needs SQ_W + 2*FRAC_BITS bits and its root half of that.
  localparam int QUOT_W = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W = QUOT_W / 2;
  localparam int RMS_W  = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEIGHT = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== hw/rtl/rpd_lane.sv =====
// ----------------------------------------------------------------------------
// rpd_lane: one colour lane
// Registers the square of the absolute difference of two colour components.
// ----------------------------------------------------------------------------
module rpd_lane (
  input  logic                          clk,
  input  logic                          load,
  input  logic [rpd_pkg::COLOUR_W-1:0]  one,
  input  logic [rpd_pkg::COLOUR_W-1:0]  two,
  output logic [rpd_pkg::SQ_W-1:0]      square
);

  logic [rpd_pkg::COLOUR_W-1:0] diff;

  assign diff = (one >= two) ? (one - two) : (two - one);

  always_ff @(posedge clk) begin
    if (load) begin
      square <= rpd_pkg::SQ_W'(diff * diff);
    end
  end

endmodule

// ===== hw/rtl/rpd_divider.sv =====
// ----------------------------------------------------------------------------
// rpd_divider: restoring divider for the scaled mean
// Works out floor(num * 4^FRAC_BITS / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpd_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rpd_pkg::SUM_W-1:0]   num,
  input  logic [rpd_pkg::DEN_W-1:0]   den,
  output rpd_pkg::unit_status_t       status,
  output logic [rpd_pkg::QUOT_W-1:0]  quot
);

  localparam int NUM_W = rpd_pkg::SUM_W + 2 * rpd_pkg::FRAC_BITS;
  localparam int CW    = $clog2(rpd_pkg::QUOT_W + 1);

  logic [NUM_W-1:0]            scaled;
  logic [rpd_pkg::DEN_W-1:0]   rem;
  logic [rpd_pkg::DEN_W-1:0]   divisor;
  logic [rpd_pkg::QUOT_W-1:0]  shreg;
  logic [CW-1:0]               count;
  logic                        busy;
  logic                        done;
  logic [rpd_pkg::DEN_W:0]     trial;
  logic                        ge;

  assign scaled = NUM_W'(num) << (2 * rpd_pkg::FRAC_BITS);
  assign trial  = {rem, shreg[rpd_pkg::QUOT_W-1]};
  assign ge     = trial >= {1'b0, divisor};

  // The quotient is known to fit in QUOT_W bits, so the bits of the scaled
  // numerator above them are already smaller than the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= rpd_pkg::DEN_W'(scaled >> rpd_pkg::QUOT_W);
      shreg   <= scaled[rpd_pkg::QUOT_W-1:0];
      divisor <= den;
    end else if (busy) begin
      rem   <= ge ? rpd_pkg::DEN_W'(trial - {1'b0, divisor}) : rpd_pkg::DEN_W'(trial);
      shreg <= {shreg[rpd_pkg::QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(rpd_pkg::QUOT_W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = shreg;

endmodule

// ===== hw/rtl/rpd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rpd_sqrt: digit-by-digit integer square root
// Produces one root bit per cycle and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rpd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rpd_pkg::QUOT_W-1:0]  radicand,
  input  logic                        ack,
  output rpd_pkg::unit_status_t       status,
  output logic [rpd_pkg::ROOT_W-1:0]  root
);

  localparam int CW = $clog2(rpd_pkg::ROOT_W + 1);

  logic [rpd_pkg::QUOT_W-1:0]  rad;
  logic [rpd_pkg::ROOT_W+1:0]  rem;
  logic [rpd_pkg::ROOT_W+1:0]  acc;
  logic [rpd_pkg::ROOT_W+1:0]  trial;
  logic                        ge;
  logic [CW-1:0]               count;
  logic                        busy;
  logic                        held;

  // Before a shift the remainder is at most twice the partial root, which
  // still has a free top bit, so dropping its two upper bits loses nothing.
  assign acc   = {rem[rpd_pkg::ROOT_W-1:0], rad[rpd_pkg::QUOT_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign ge    = acc >= trial;

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? (acc - trial) : acc;
      root <= {root[rpd_pkg::ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      held  <= 1'b0;
      count <= '0;
    end else begin
      if (ack) begin
        held <= 1'b0;
      end
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(rpd_pkg::ROOT_W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          held <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = held;

endmodule

// ===== hw/rtl/rms_pixel_difference.sv =====
// ----------------------------------------------------------------------------
// rms_pixel_difference: root mean square difference of two RGB images
// Accumulates squared colour differences over the overlap of two images and
// reports the truncated 8.8 root mean square difference once per frame.
// ----------------------------------------------------------------------------
// Usage: write the four image sizes on the configuration port (cfg_ready is
// always high) while the block is idle; the pixel channel stalls for one
// cycle after each write while the overlap size settles. Pixel pairs enter
// on the pix channel, one item per cycle while pix_stall is low, through
// three colour lanes whose squares a merge adder sums into an exact
// accumulator. The item that completes the overlap closes the frame: the
// pixel channel then stalls while a restoring divider and a square root
// unit run; the result item is offered once the root is done and the output
// register is free, and the next pixel item can be accepted in the same
// cycle as the result item is offered. The result goes to an output
// register; the next frame may start streaming while it waits on
// res_stall, and only a further frame end stalls until that result is taken.
// Reset clears the sum, the pixel count and all handshake state and sets
// every size to one pixel.
// ----------------------------------------------------------------------------
module rms_pixel_difference (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::DIM_W-1:0]      cfg_data,

  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  logic [rpd_pkg::COLOUR_W-1:0]   red_one,
  input  logic [rpd_pkg::COLOUR_W-1:0]   green_one,
  input  logic [rpd_pkg::COLOUR_W-1:0]   blue_one,
  input  logic [rpd_pkg::COLOUR_W-1:0]   red_two,
  input  logic [rpd_pkg::COLOUR_W-1:0]   green_two,
  input  logic [rpd_pkg::COLOUR_W-1:0]   blue_two,

  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [rpd_pkg::RMS_W-1:0]      rms_value,
  output logic                           size_mismatch
);

  localparam int EXT_W = (rpd_pkg::ROOT_W > rpd_pkg::RMS_W) ? rpd_pkg::ROOT_W
                                                             : rpd_pkg::RMS_W;

  function automatic logic [rpd_pkg::SIDE_W-1:0] clamp_dim(
    input logic [rpd_pkg::DIM_W-1:0] v
  );
    logic [rpd_pkg::SIDE_W-1:0] r;
    if (v == '0) begin
      r = rpd_pkg::SIDE_W'(1);
    end else if (32'(v) > rpd_pkg::MAX_DIM) begin
      r = rpd_pkg::SIDE_W'(rpd_pkg::MAX_DIM);
    end else begin
      r = rpd_pkg::SIDE_W'(v);
    end
    return r;
  endfunction

  function automatic logic far_apart(
    input logic [rpd_pkg::SIDE_W-1:0] a,
    input logic [rpd_pkg::SIDE_W-1:0] b
  );
    logic [rpd_pkg::SIDE_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d > rpd_pkg::SIDE_W'(1);
  endfunction

  // Configuration registers and the derived overlap size.
  logic [rpd_pkg::DIM_W-1:0]   first_width;
  logic [rpd_pkg::DIM_W-1:0]   first_height;
  logic [rpd_pkg::DIM_W-1:0]   second_width;
  logic [rpd_pkg::DIM_W-1:0]   second_height;
  logic [rpd_pkg::SIDE_W-1:0]  w1, h1, w2, h2, min_w, min_h;
  logic [rpd_pkg::CNT_W-1:0]   total;
  logic                        mismatch;
  logic                        settle;
  logic                        cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_width   <= rpd_pkg::DIM_W'(1);
      first_height  <= rpd_pkg::DIM_W'(1);
      second_width  <= rpd_pkg::DIM_W'(1);
      second_height <= rpd_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        rpd_pkg::REG_FIRST_WIDTH:   first_width   <= cfg_data;
        rpd_pkg::REG_FIRST_HEIGHT:  first_height  <= cfg_data;
        rpd_pkg::REG_SECOND_WIDTH:  second_width  <= cfg_data;
        rpd_pkg::REG_SECOND_HEIGHT: second_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w1    = clamp_dim(first_width);
  assign h1    = clamp_dim(first_height);
  assign w2    = clamp_dim(second_width);
  assign h2    = clamp_dim(second_height);
  assign min_w = (w1 <= w2) ? w1 : w2;
  assign min_h = (h1 <= h2) ? h1 : h2;

  // The overlap product is registered; pixels are held off for the cycle
  // after a write so that no item sees a stale size.
  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= rpd_pkg::CNT_W'(1);
      mismatch <= 1'b0;
      settle   <= 1'b0;
    end else begin
      total    <= rpd_pkg::CNT_W'(min_w * min_h);
      mismatch <= far_apart(w1, w2) | far_apart(h1, h2);
      settle   <= cfg_write;
    end
  end

  // Pixel acceptance and counting.
  logic                        pix_take;
  logic [rpd_pkg::CNT_W-1:0]   pixel_count;
  logic [rpd_pkg::CNT_W-1:0]   count_next;
  logic                        last;
  logic [rpd_pkg::CNT_W-1:0]   frame_count;
  logic                        frame_mismatch;
  logic                        lane_valid;
  logic                        lane_last;
  rpd_pkg::unit_status_t       div_st;
  rpd_pkg::unit_status_t       sq_st;

  assign pix_stall  = settle | (lane_valid & lane_last) | div_st.busy | div_st.done
                    | sq_st.busy | sq_st.done;
  assign pix_take   = pix_valid & ~pix_stall;
  assign count_next = pixel_count + rpd_pkg::CNT_W'(1);
  assign last       = count_next >= total;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
      lane_valid  <= 1'b0;
      lane_last   <= 1'b0;
    end else begin
      lane_valid <= pix_take;
      if (pix_take) begin
        pixel_count <= last ? '0 : count_next;
        lane_last   <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take && last) begin
      frame_count    <= count_next;
      frame_mismatch <= mismatch;
    end
  end

  logic [rpd_pkg::SQ_W-1:0] sq_red, sq_green, sq_blue;

  rpd_lane u_lane_red (
    .clk    (clk),
    .load   (pix_take),
    .one    (red_one),
    .two    (red_two),
    .square (sq_red)
  );

  rpd_lane u_lane_green (
    .clk    (clk),
    .load   (pix_take),
    .one    (green_one),
    .two    (green_two),
    .square (sq_green)
  );

  rpd_lane u_lane_blue (
    .clk    (clk),
    .load   (pix_take),
    .one    (blue_one),
    .two    (blue_two),
    .square (sq_blue)
  );

  // Merge stage: the three lane squares go into the frame sum.
  logic [rpd_pkg::SUM_W-1:0]  squared_sum;
  logic [rpd_pkg::SUM_W-1:0]  sum_next;
  logic [rpd_pkg::DEN_W-1:0]  den;
  logic                       div_start;

  assign sum_next  = squared_sum + rpd_pkg::SUM_W'(sq_red) + rpd_pkg::SUM_W'(sq_green)
                   + rpd_pkg::SUM_W'(sq_blue);
  assign div_start = lane_valid & lane_last;
  assign den       = rpd_pkg::DEN_W'({frame_count, 1'b0}) + rpd_pkg::DEN_W'(frame_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      squared_sum <= '0;
    end else if (lane_valid) begin
      squared_sum <= lane_last ? '0 : sum_next;
    end
  end

  logic [rpd_pkg::QUOT_W-1:0] quot;
  logic [rpd_pkg::ROOT_W-1:0] root;
  logic [EXT_W-1:0]           root_ext;
  logic                       res_load;

  rpd_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (sum_next),
    .den    (den),
    .status (div_st),
    .quot   (quot)
  );

  rpd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (div_st.done),
    .radicand (quot),
    .ack      (res_load),
    .status   (sq_st),
    .root     (root)
  );

  assign res_load = sq_st.done & (~res_valid | ~res_stall);
  assign root_ext = EXT_W'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rms_value     <= (root_ext > EXT_W'({rpd_pkg::RMS_W{1'b1}}))
                     ? {rpd_pkg::RMS_W{1'b1}} : rpd_pkg::RMS_W'(root_ext);
      size_mismatch <= frame_mismatch;
    end
  end

  // No pixel may enter while a frame result is still being worked out.
  assert property (@(posedge clk) disable iff (rst)
    pix_take |-> !(div_st.busy || sq_st.busy))
    else $error("pixel item accepted while the frame result is in progress");

  // The root unit must be free whenever the divider hands over a quotient.
  assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> !(sq_st.busy || sq_st.done))
    else $error("divider finished while the root unit was occupied");

  // A fresh result only appears after the root unit held one.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(sq_st.done))
    else $error("result item raised without a finished root");

  // The divider starts only after the closing item of a frame.
  assert property (@(posedge clk) disable iff (rst)
    div_st.busy && !$past(div_st.busy) |-> $past(lane_valid && lane_last))
    else $error("divider started without a closing item");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RMS pixel difference block
// A short table of directed items covers the colour extremes, the clamping of
// out-of-range sizes, the size mismatch flag and a size change in the middle
// of a frame. Random phases with random image sizes and a small overlap
// follow. Every frame result is compared with a table value or a local
// predictor while pixel items pause and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int FRAME_DRAIN  = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int COLOUR_LANES = 3;

  typedef enum logic {ROW_SIZE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    logic [rpd_pkg::COLOUR_W-1:0] red_one;
    logic [rpd_pkg::COLOUR_W-1:0] green_one;
    logic [rpd_pkg::COLOUR_W-1:0] blue_one;
    logic [rpd_pkg::COLOUR_W-1:0] red_two;
    logic [rpd_pkg::COLOUR_W-1:0] green_two;
    logic [rpd_pkg::COLOUR_W-1:0] blue_two;
  } pixel_t;

  typedef struct packed {
    logic [rpd_pkg::RMS_W-1:0] rms;
    logic                      mis;
  } rms_result_t;

  typedef struct {
    row_kind_t                      kind;
    logic [rpd_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rpd_pkg::DIM_W-1:0]      size;
    pixel_t                         pix;
    bit                             known;
    rms_result_t                    known_result;
  } stim_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index = rpd_pkg::REG_FIRST_WIDTH;
  logic [rpd_pkg::DIM_W-1:0]     cfg_data = '0;
  logic                          pix_valid = 1'b0;
  logic                          pix_stall;
  logic [rpd_pkg::COLOUR_W-1:0]  red_one = '0;
  logic [rpd_pkg::COLOUR_W-1:0]  green_one = '0;
  logic [rpd_pkg::COLOUR_W-1:0]  blue_one = '0;
  logic [rpd_pkg::COLOUR_W-1:0]  red_two = '0;
  logic [rpd_pkg::COLOUR_W-1:0]  green_two = '0;
  logic [rpd_pkg::COLOUR_W-1:0]  blue_two = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  logic [rpd_pkg::RMS_W-1:0]     rms_value;
  logic                          size_mismatch;

  // Predictor state: the size registers as written and the running frame.
  logic [rpd_pkg::DIM_W-1:0]     size_reg [4];
  logic [rpd_pkg::SUM_W-1:0]     frame_sum = '0;
  logic [rpd_pkg::CNT_W-1:0]     frame_count = '0;

  rms_result_t          awaited_results [$];
  stim_row_t            directed_rows [$];
  bit                   calm = 1'b0;
  int                   stall_left = 0;
  int                   cycle_count = 0;
  int                   mismatch_count = 0;
  int                   results_checked = 0;
  int                   items_sent = 0;
  int                   size_writes = 0;

  rms_pixel_difference DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .red_one      (red_one),
    .green_one    (green_one),
    .blue_one     (blue_one),
    .red_two      (red_two),
    .green_two    (green_two),
    .blue_two     (blue_two),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .rms_value    (rms_value),
    .size_mismatch(size_mismatch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [rpd_pkg::SIDE_W-1:0] clamp_side(
    input logic [rpd_pkg::DIM_W-1:0] v
  );
    if (v == '0) return rpd_pkg::SIDE_W'(1);
    if (v > rpd_pkg::DIM_W'(rpd_pkg::MAX_DIM)) return rpd_pkg::SIDE_W'(rpd_pkg::MAX_DIM);
    return rpd_pkg::SIDE_W'(v);
  endfunction

  function automatic logic [rpd_pkg::SIDE_W-1:0] lesser(
    input logic [rpd_pkg::SIDE_W-1:0] a, b
  );
    return (a <= b) ? a : b;
  endfunction

  function automatic bit far_apart(input logic [rpd_pkg::SIDE_W-1:0] a, b);
    logic [rpd_pkg::SIDE_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return d > rpd_pkg::SIDE_W'(1);
  endfunction

  function automatic logic [rpd_pkg::SQ_W-1:0] sq_diff(
    input logic [rpd_pkg::COLOUR_W-1:0] a, b
  );
    logic [rpd_pkg::COLOUR_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return rpd_pkg::SQ_W'(d) * rpd_pkg::SQ_W'(d);
  endfunction

  function automatic logic [rpd_pkg::CNT_W-1:0] overlap_size();
    logic [rpd_pkg::SIDE_W-1:0] w;
    logic [rpd_pkg::SIDE_W-1:0] h;
    w = lesser(clamp_side(size_reg[rpd_pkg::REG_FIRST_WIDTH]),
               clamp_side(size_reg[rpd_pkg::REG_SECOND_WIDTH]));
    h = lesser(clamp_side(size_reg[rpd_pkg::REG_FIRST_HEIGHT]),
               clamp_side(size_reg[rpd_pkg::REG_SECOND_HEIGHT]));
    return rpd_pkg::CNT_W'(w) * rpd_pkg::CNT_W'(h);
  endfunction

  // Bit-by-bit integer square root, largest root whose square fits.
  function automatic logic [31:0] int_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_pixel(input pixel_t p, output bit closes,
                                  output rms_result_t res);
    logic [rpd_pkg::SIDE_W-1:0] w1, h1, w2, h2;
    logic [63:0]                quot;
    logic [31:0]                root;
    w1 = clamp_side(size_reg[rpd_pkg::REG_FIRST_WIDTH]);
    h1 = clamp_side(size_reg[rpd_pkg::REG_FIRST_HEIGHT]);
    w2 = clamp_side(size_reg[rpd_pkg::REG_SECOND_WIDTH]);
    h2 = clamp_side(size_reg[rpd_pkg::REG_SECOND_HEIGHT]);
    frame_sum = frame_sum + rpd_pkg::SUM_W'(sq_diff(p.red_one, p.red_two))
                          + rpd_pkg::SUM_W'(sq_diff(p.green_one, p.green_two))
                          + rpd_pkg::SUM_W'(sq_diff(p.blue_one, p.blue_two));
    frame_count = frame_count + rpd_pkg::CNT_W'(1);
    closes = (frame_count >= overlap_size());
    res = '0;
    if (closes) begin
      quot = (64'(frame_sum) << (2 * rpd_pkg::FRAC_BITS))
           / (64'(frame_count) * COLOUR_LANES);
      root = int_root(quot);
      res.rms = (root > 32'hFFFF) ? 16'hFFFF : root[rpd_pkg::RMS_W-1:0];
      res.mis = far_apart(w1, w2) || far_apart(h1, h2);
      frame_sum = '0;
      frame_count = '0;
    end
  endtask

  function automatic pixel_t px(input logic [rpd_pkg::COLOUR_W-1:0] r1, g1, b1,
                                r2, g2, b2);
    pixel_t p;
    p = '{r1, g1, b1, r2, g2, b2};
    return p;
  endfunction

  function automatic pixel_t random_pixel(input int style);
    logic [rpd_pkg::COLOUR_W-1:0] c [6];
    foreach (c[k]) begin
      if (style == 1) c[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else c[k] = rpd_pkg::COLOUR_W'($urandom);
    end
    // Nearly equal images: the second pixel differs only in its low bits.
    if (style == 2) begin
      for (int k = 0; k < 3; k++)
        c[k + 3] = c[k] ^ rpd_pkg::COLOUR_W'($urandom_range(0, 3));
    end
    return px(c[0], c[1], c[2], c[3], c[4], c[5]);
  endfunction

  function automatic void add_size(input logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [rpd_pkg::DIM_W-1:0] v);
    stim_row_t r;
    r = '{kind: ROW_SIZE, reg_index: idx, size: v, pix: '0, known: 1'b0,
          known_result: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pixel(input pixel_t p, input bit known,
                                    input logic [rpd_pkg::RMS_W-1:0] rms,
                                    input logic mis);
    stim_row_t r;
    r = '{kind: ROW_PIXEL, reg_index: rpd_pkg::REG_FIRST_WIDTH, size: '0, pix: p,
          known: known, known_result: '{rms: rms, mis: mis}};
    directed_rows.push_back(r);
  endfunction

  // Leaves pix_valid high; the caller decides whether the next item follows.
  task automatic send_pixel(input pixel_t p, output bit closes, output rms_result_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    red_one   <= p.red_one;
    green_one <= p.green_one;
    blue_one  <= p.blue_one;
    red_two   <= p.red_two;
    green_two <= p.green_two;
    blue_two  <= p.blue_two;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!(pix_valid === 1'b1 && pix_stall === 1'b0));
    accumulate_pixel(p, closes, res);
    items_sent++;
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic set_size(input logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                          input logic [rpd_pkg::DIM_W-1:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    size_reg[idx] = v;
    size_writes++;
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (FRAME_DRAIN) @(posedge clk);
  endtask

  function automatic logic [rpd_pkg::DIM_W-1:0] random_side();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return rpd_pkg::DIM_W'($urandom_range(rpd_pkg::MAX_DIM + 1, 8191));
    if (roll == 2) return rpd_pkg::DIM_W'($urandom_range(7, rpd_pkg::MAX_DIM));
    return rpd_pkg::DIM_W'($urandom_range(1, 5));
  endfunction

  task automatic program_random_sizes();
    logic [rpd_pkg::DIM_W-1:0] fw, fh, sw, sh;
    fw = random_side();
    fh = random_side();
    sw = random_side();
    sh = random_side();
    if ($urandom_range(0, 1) && fw >= 1 && fw <= 5)
      sw = fw + rpd_pkg::DIM_W'($urandom_range(0, 1));
    if ($urandom_range(0, 1) && fh >= 1 && fh <= 5)
      sh = fh + rpd_pkg::DIM_W'($urandom_range(0, 1));
    // Keep the overlap small so that frames stay short.
    if (clamp_side(fw) > 6 && clamp_side(sw) > 6) sw = rpd_pkg::DIM_W'($urandom_range(1, 6));
    if (clamp_side(fh) > 6 && clamp_side(sh) > 6) sh = rpd_pkg::DIM_W'($urandom_range(1, 6));
    wait_idle();
    set_size(rpd_pkg::REG_FIRST_WIDTH, fw);
    set_size(rpd_pkg::REG_FIRST_HEIGHT, fh);
    set_size(rpd_pkg::REG_SECOND_WIDTH, sw);
    set_size(rpd_pkg::REG_SECOND_HEIGHT, sh);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    bit          closes;
    bit          cfg_open;
    rms_result_t res;
    int          random_items;
    int          frame_items;
    int          style;
    int          total;

    foreach (size_reg[k]) size_reg[k] = rpd_pkg::DIM_W'(1);
    cfg_open = 1'b0;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sizes are one pixel after reset, so each item is a frame of its own.
    add_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 16'h0000, 1'b0);
    add_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00), 1'b1, 16'hFF00, 1'b0);
    add_pixel(px(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1'b1, 16'hFF00, 1'b0);
    add_pixel(px(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0, 1'b0);
    add_pixel(px(8'h0F, 8'hF0, 8'h55, 8'hF0, 8'h0F, 8'hAA), 1'b0, '0, 1'b0);
    add_pixel(px(8'h80, 8'h01, 8'hFE, 8'h7F, 8'h02, 8'hFF), 1'b0, '0, 1'b0);
    // A zero width counts as one and an oversized height as the maximum.
    add_size(rpd_pkg::REG_FIRST_WIDTH, 13'd0);
    add_size(rpd_pkg::REG_FIRST_HEIGHT, 13'h1FFF);
    add_size(rpd_pkg::REG_SECOND_WIDTH, 13'd3);
    add_size(rpd_pkg::REG_SECOND_HEIGHT, 13'd2);
    add_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00), 1'b0, '0, 1'b0);
    add_pixel(px(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1'b1, 16'hFF00, 1'b1);
    // Sizes differing by one are not a mismatch; the frame is left unfinished.
    add_size(rpd_pkg::REG_FIRST_WIDTH, 13'd4);
    add_size(rpd_pkg::REG_FIRST_HEIGHT, 13'd2);
    add_size(rpd_pkg::REG_SECOND_WIDTH, 13'd5);
    add_size(rpd_pkg::REG_SECOND_HEIGHT, 13'd3);
    add_pixel(px(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC), 1'b0, '0, 1'b0);
    add_pixel(px(8'hDE, 8'hF0, 8'h01, 8'h23, 8'h45, 8'h67), 1'b0, '0, 1'b0);
    add_pixel(px(8'h89, 8'hAB, 8'hCD, 8'hEF, 8'h10, 8'h32), 1'b0, '0, 1'b0);
    // Shrinking the overlap below the count so far: the next item closes the frame.
    add_size(rpd_pkg::REG_FIRST_WIDTH, 13'd1);
    add_pixel(px(8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE), 1'b0, '0, 1'b0);
    add_size(rpd_pkg::REG_FIRST_WIDTH, 13'd4096);
    add_size(rpd_pkg::REG_SECOND_WIDTH, 13'd2);
    add_pixel(px(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06), 1'b0, '0, 1'b0);
    add_pixel(px(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00), 1'b0, '0, 1'b0);
    add_pixel(px(8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80), 1'b0, '0, 1'b0);
    add_pixel(px(8'hC3, 8'h3C, 8'hA5, 8'h5A, 8'h99, 8'h66), 1'b0, '0, 1'b0);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_SIZE) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        set_size(directed_rows[n].reg_index, directed_rows[n].size);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_pixel(directed_rows[n].pix, closes, res);
        if (closes)
          awaited_results.push_back(directed_rows[n].known ? directed_rows[n].known_result
                                                           : res);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      program_random_sizes();
      total = int'(overlap_size());
      frame_items = $urandom_range(1, 4) * total;
      if ($urandom_range(0, 3) == 0) frame_items += $urandom_range(0, total - 1);
      style = $urandom_range(0, 2);
      repeat (frame_items) begin
        send_pixel(random_pixel(style), closes, res);
        if (closes) awaited_results.push_back(res);
        random_items++;
      end
    end

    calm = 1'b0;
    wait_idle();
    $display("Sent %0d pixel items with %0d size register writes; %0d frame results checked.",
             items_sent, size_writes, results_checked);
    $display("Directed table, then random small and clamped sizes: %0d errors.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    rms_result_t want;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid === 1'b1 && res_stall === 1'b0) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected: rms_value %h size_mismatch %b",
                   $time, rms_value, size_mismatch);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (rms_value !== want.rms) begin
            mismatch_count++;
            $display("%0t: rms_value expected %h actual %h", $time, want.rms, rms_value);
          end
          if (size_mismatch !== want.mis) begin
            mismatch_count++;
            $display("%0t: size_mismatch expected %b actual %b", $time, want.mis,
                     size_mismatch);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        res_stall  <= !calm && ($urandom_range(0, 2) == 0);
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

endmodule

// ===== rms_pixel_difference.f =====
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_lane.sv
hw/rtl/rpd_divider.sv
hw/rtl/rpd_sqrt.sv
hw/rtl/rms_pixel_difference.sv
tb/tb_top.sv
